// ===== hdl/lfu_pkg.sv =====
// Shared types and constants for the LFU key table.
package lfu_pkg;
    localparam int CAPACITY   = 16;
    localparam int COUNT_BITS = 16;
    localparam int KEY_W      = 32;
    localparam int STAMP_W    = 32;
    localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int OCC_W      = $clog2(CAPACITY + 1);
    localparam int CFG_W      = 5;
    localparam int OUT_CNT_W  = 16;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISS    = 2'd1;
    localparam logic [1:0] ST_PRESENT = 2'd2;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_UPDATE} state_t;

    typedef struct packed {
        logic [KEY_W-1:0]      key;
        logic [STAMP_W-1:0]    seq;
        logic                  hit;
        logic [IDX_W-1:0]      hit_idx;
        logic [COUNT_BITS-1:0] hit_count;
        logic                  have_best;
        logic [IDX_W-1:0]      best_idx;
        logic [COUNT_BITS-1:0] best_count;
        logic [STAMP_W-1:0]    best_age;
        logic [KEY_W-1:0]      best_key;
        logic                  free;
        logic [IDX_W-1:0]      free_idx;
    } probe_t;

    typedef struct packed {
        logic                  hit_en;
        logic [IDX_W-1:0]      hit_idx;
        logic [COUNT_BITS-1:0] hit_count;
        logic                  evict_en;
        logic [IDX_W-1:0]      evict_idx;
        logic                  ins_en;
        logic [IDX_W-1:0]      ins_idx;
        logic [KEY_W-1:0]      key;
        logic [STAMP_W-1:0]    stamp;
    } upd_t;
endpackage

// ===== hdl/lfu_cell.sv =====
// One table slot: holds an entry, folds it into the passing probe, applies updates.
module lfu_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [lfu_pkg::IDX_W-1:0] slot_idx,
    input  lfu_pkg::probe_t       probe_in,
    input  lfu_pkg::upd_t         upd,
    output lfu_pkg::probe_t       probe_out
);
    import lfu_pkg::*;

    logic [KEY_W-1:0]      key_reg;
    logic [STAMP_W-1:0]    stamp_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic                  valid_reg;
    probe_t                probe_reg, probe_next;
    logic [STAMP_W-1:0]    age;
    logic                  take;

    always_comb begin
        age = probe_in.seq - stamp_reg;
        take = 1'b0;
        probe_next = probe_in;
        if (valid_reg) begin
            if (!probe_in.hit && key_reg == probe_in.key) begin
                probe_next.hit       = 1'b1;
                probe_next.hit_idx   = slot_idx;
                probe_next.hit_count = count_reg;
            end
            if (!probe_in.have_best || count_reg < probe_in.best_count) begin
                take = 1'b1;
            end else if (count_reg == probe_in.best_count) begin
                take = (count_reg == COUNT_ONE) ? (age > probe_in.best_age)
                                                : (age < probe_in.best_age);
            end
            if (take) begin
                probe_next.have_best  = 1'b1;
                probe_next.best_idx   = slot_idx;
                probe_next.best_count = count_reg;
                probe_next.best_age   = age;
                probe_next.best_key   = key_reg;
            end
        end else if (!probe_in.free) begin
            probe_next.free     = 1'b1;
            probe_next.free_idx = slot_idx;
        end
    end

    always_ff @(posedge aclk) begin
        probe_reg <= probe_next;
        if (!aresetn) begin
            valid_reg <= 1'b0;
            count_reg <= '0;
        end else begin
            if (upd.hit_en && upd.hit_idx == slot_idx) begin
                count_reg <= upd.hit_count;
                stamp_reg <= upd.stamp;
            end
            if (upd.evict_en && upd.evict_idx == slot_idx) begin
                valid_reg <= 1'b0;
                count_reg <= '0;
            end
            if (upd.ins_en && upd.ins_idx == slot_idx) begin
                valid_reg <= 1'b1;
                count_reg <= COUNT_ONE;
                key_reg   <= upd.key;
                stamp_reg <= upd.stamp;
            end
        end
    end

    assign probe_out = probe_reg;
endmodule

// ===== hdl/lfu_cache_table.sv =====
// Top level of the LFU key table: request control and a chain of slot cells.
//  channel | ports            | contents
//  in      | s_tvalid/tready  | s_tuser opcode, s_tdata key
//  out     | m_tvalid/tready  | m_tuser status, m_tdata count/evicted/evicted key
//  config  | cfg_we           | cfg_wdata capacity_in_use
// A request is taken only in idle: the probe walks the slot chain one cell per
// cycle, then the update state applies the result. Reset empties the table and sets
// capacity to 16. A stalled result holds the update state until taken.
module lfu_cache_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] key
    input  logic [0:0]  s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [15:0] use_count, [16] evicted, [48:17] evicted_key
    output logic [1:0]  m_tuser,   // [1:0] status
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata  // [4:0] capacity_in_use
);
    import lfu_pkg::*;

    state_t                state_reg, state_next;
    logic [IDX_W-1:0]      cnt_reg, cnt_next;
    logic [CFG_W-1:0]      cap_reg;
    logic [OCC_W-1:0]      occ_reg, occ_next;
    logic [STAMP_W-1:0]    seq_reg, seq_next;
    logic                  op_reg;
    logic [KEY_W-1:0]      key_reg;
    logic                  out_valid_reg;
    logic [1:0]            out_status_reg;
    logic [OUT_CNT_W-1:0]  out_count_reg;
    logic                  out_ev_reg;
    logic [KEY_W-1:0]      out_evkey_reg;

    probe_t                chain [CAPACITY+1];
    upd_t                  upd;
    probe_t                pr;
    logic [OCC_W-1:0]      eff_cap;
    logic                  load_out;
    logic                  evict;
    logic [1:0]            status;
    logic [COUNT_BITS-1:0] count;

    always_comb begin
        chain[0] = '0;
        chain[0].key = key_reg;
        chain[0].seq = seq_reg;
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        lfu_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .slot_idx  (IDX_W'(i)),
            .probe_in  (chain[i]),
            .upd       (upd),
            .probe_out (chain[i+1])
        );
    end

    assign pr = chain[CAPACITY];

    always_comb begin
        if (cap_reg == '0) begin
            eff_cap = OCC_W'(1);
        end else if ({{(OCC_W+CFG_W){1'b0}}, cap_reg} > (OCC_W+2*CFG_W)'(CAPACITY)) begin
            eff_cap = OCC_W'(CAPACITY);
        end else begin
            eff_cap = OCC_W'(cap_reg);
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        load_out   = 1'b0;
        upd        = '0;
        upd.key    = key_reg;
        upd.stamp  = seq_reg;
        occ_next   = occ_reg;
        seq_next   = seq_reg;
        status     = ST_OK;
        count      = '0;
        evict      = 1'b0;
        if (op_reg == OP_ACCESS) begin
            if (pr.hit) begin
                count = (pr.hit_count == COUNT_MAX) ? pr.hit_count : pr.hit_count + COUNT_ONE;
            end else begin
                status = ST_MISS;
            end
        end else if (pr.hit) begin
            status = ST_PRESENT;
            count  = pr.hit_count;
        end else begin
            evict = (occ_reg >= eff_cap) && pr.have_best;
            if (evict || pr.free) begin
                count = COUNT_ONE;
            end
        end
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_SCAN;
                    cnt_next   = '0;
                end
            end
            S_SCAN: begin
                if (cnt_reg == IDX_W'(CAPACITY - 1)) begin
                    state_next = S_UPDATE;
                end else begin
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end
            S_UPDATE: begin
                if (!out_valid_reg || m_tready) begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                    if (op_reg == OP_ACCESS) begin
                        if (pr.hit) begin
                            upd.hit_en    = 1'b1;
                            upd.hit_idx   = pr.hit_idx;
                            upd.hit_count = count;
                            seq_next      = seq_reg + STAMP_W'(1);
                        end
                    end else if (!pr.hit) begin
                        upd.evict_en  = evict;
                        upd.evict_idx = pr.best_idx;
                        upd.ins_en    = evict || pr.free;
                        upd.ins_idx   = (evict && !(pr.free && pr.free_idx < pr.best_idx))
                                        ? pr.best_idx : pr.free_idx;
                        if (upd.ins_en) begin
                            seq_next = seq_reg + STAMP_W'(1);
                            if (!evict) begin
                                occ_next = occ_reg + OCC_W'(1);
                            end
                        end
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            cap_reg       <= CFG_W'(16);
            occ_reg       <= '0;
            seq_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            occ_reg   <= occ_next;
            seq_reg   <= seq_next;
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
        if (s_tvalid && s_tready) begin
            op_reg  <= s_tuser[0];
            key_reg <= s_tdata;
        end
        if (load_out) begin
            out_status_reg <= status;
            out_count_reg  <= OUT_CNT_W'(count);
            out_ev_reg     <= upd.evict_en;
            out_evkey_reg  <= upd.evict_en ? pr.best_key : '0;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {7'b0, out_evkey_reg, out_ev_reg, out_count_reg};
endmodule

// ===== hdl/lfu_checker.sv =====
// Port-level checks for the LFU key table, bound to the top level.
module lfu_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [1:0]  m_tuser
);
    import lfu_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped while stalled");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("request taken during scan");
    a_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_MISS |-> m_tdata[16:0] == 17'd0)
        else $error("miss with count or eviction");
    a_evk: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[16] |-> m_tdata[48:17] == 32'd0)
        else $error("evicted key without eviction");
endmodule

bind lfu_cache_table lfu_checker u_lfu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/sv/lfu_cache_table_tb.sv =====
// Self-checking testbench for the LFU key table: queued stimulus, predicted results, stream checks.
module lfu_cache_table_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lfu_pkg::*;

    typedef struct packed {
        logic        op;
        logic [31:0] key;
    } request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] use_count;
        logic        evicted;
        logic [31:0] evicted_key;
    } reply_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_we = 1'b0;
    logic [4:0]  cfg_wdata = '0;

    lfu_cache_table uut (.*);

    always #10 aclk = ~aclk;

    // table shadow
    logic [31:0]           tbl_key [CAPACITY];
    logic [COUNT_BITS-1:0] tbl_count [CAPACITY];
    logic                  tbl_valid [CAPACITY];
    logic [31:0]           tbl_stamp [CAPACITY];
    logic [31:0]           seq_now;
    int unsigned           fill_level;
    logic [4:0]            cap_reg;

    request_t    pending_requests[$];
    reply_t      expected_replies[$];
    int          error_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_cycles = 0;
    longint      cycle_count = 0;

    function automatic reply_t predict_lfu(request_t rq);
        reply_t r;
        int hit, best, freei, capn;
        logic [31:0] age, best_age;
        r = '0;
        hit = -1;
        for (int i = 0; i < CAPACITY; i++)
            if (hit < 0 && tbl_valid[i] && tbl_key[i] == rq.key) hit = i;
        if (rq.op == OP_ACCESS) begin
            if (hit < 0) begin
                r.status = ST_MISS;
            end else begin
                if (tbl_count[hit] != COUNT_MAX) tbl_count[hit] = tbl_count[hit] + 1'b1;
                tbl_stamp[hit] = seq_now;
                seq_now = seq_now + 32'd1;
                r.status = ST_OK;
                r.use_count = tbl_count[hit];
            end
        end else if (hit >= 0) begin
            r.status = ST_PRESENT;
            r.use_count = tbl_count[hit];
        end else begin
            r.status = ST_OK;
            capn = (cap_reg == 0) ? 1 : (cap_reg > CAPACITY ? CAPACITY : cap_reg);
            if (fill_level >= capn) begin
                best = -1;
                for (int i = 0; i < CAPACITY; i++) begin
                    if (!tbl_valid[i]) continue;
                    if (best < 0) begin
                        best = i;
                        continue;
                    end
                    if (tbl_count[i] < tbl_count[best]) begin
                        best = i;
                        continue;
                    end
                    if (tbl_count[i] > tbl_count[best]) continue;
                    age = seq_now - tbl_stamp[i];
                    best_age = seq_now - tbl_stamp[best];
                    if (tbl_count[i] == COUNT_ONE) begin
                        if (age > best_age) best = i;
                    end else if (age < best_age) begin
                        best = i;
                    end
                end
                if (best >= 0) begin
                    r.evicted = 1'b1;
                    r.evicted_key = tbl_key[best];
                    tbl_valid[best] = 1'b0;
                    tbl_count[best] = '0;
                    if (fill_level > 0) fill_level--;
                end
            end
            freei = -1;
            for (int i = 0; i < CAPACITY; i++)
                if (freei < 0 && !tbl_valid[i]) freei = i;
            if (freei >= 0) begin
                tbl_valid[freei] = 1'b1;
                tbl_key[freei] = rq.key;
                tbl_count[freei] = COUNT_ONE;
                tbl_stamp[freei] = seq_now;
                seq_now = seq_now + 32'd1;
                fill_level++;
                r.use_count = COUNT_ONE;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                request_t rq;
                rq = pending_requests.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= rq.key;
                s_tuser <= rq.op;
                expected_replies.push_back(predict_lfu(rq));
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            reply_t want;
            if (expected_replies.size() == 0) begin
                report_mismatch("unexpected transaction", m_tdata[31:0], '0);
            end else begin
                want = expected_replies.pop_front();
                if (m_tuser !== want.status)
                    report_mismatch("status", 32'(m_tuser), 32'(want.status));
                if (m_tdata[15:0] !== want.use_count)
                    report_mismatch("use_count", 32'(m_tdata[15:0]), 32'(want.use_count));
                if (m_tdata[16] !== want.evicted)
                    report_mismatch("evicted", 32'(m_tdata[16]), 32'(want.evicted));
                if (m_tdata[48:17] !== want.evicted_key)
                    report_mismatch("evicted_key", m_tdata[48:17], want.evicted_key);
            end
        end
    end

    always @(posedge aclk) begin
        if (cycle_count > 400000) begin
            $display("[lfu_cache_table] ERROR");
            $finish;
        end
    end

    task automatic drain();
        while (pending_requests.size() > 0 || expected_replies.size() > 0 || s_tvalid)
            @(posedge aclk);
        repeat (25) @(posedge aclk);
    endtask

    task automatic set_capacity(logic [4:0] value);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        cap_reg = value;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_key(int pool);
        case ($urandom_range(9))
            0: return $urandom();
            1: return {$urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFF0} + $urandom_range(15);
            default: return 32'(pool == 0 ? 0 : $urandom_range(pool)) ^ 32'hA5A5_0000;
        endcase
    endfunction

    task automatic queue_random(int n, int pool, int access_pct);
        request_t rq;
        for (int i = 0; i < n; i++) begin
            rq.op = ($urandom_range(99) < access_pct) ? OP_ACCESS : OP_INSERT;
            rq.key = pick_key(pool);
            pending_requests.push_back(rq);
        end
    endtask

    initial begin
        request_t rq;
        for (int i = 0; i < CAPACITY; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_count[i] = '0;
            tbl_key[i] = '0;
            tbl_stamp[i] = '0;
        end
        seq_now = '0;
        fill_level = 0;
        cap_reg = 5'd16;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: miss on empty, insert extremes, present, hits, eviction
        pending_requests.push_back('{OP_ACCESS, 32'h0000_0000});
        pending_requests.push_back('{OP_INSERT, 32'h0000_0000});
        pending_requests.push_back('{OP_INSERT, 32'hFFFF_FFFF});
        pending_requests.push_back('{OP_INSERT, 32'h8000_0000});
        pending_requests.push_back('{OP_INSERT, 32'h7FFF_FFFF});
        pending_requests.push_back('{OP_INSERT, 32'hFFFF_FFFF});
        pending_requests.push_back('{OP_ACCESS, 32'hFFFF_FFFF});
        pending_requests.push_back('{OP_ACCESS, 32'hFFFF_FFFF});
        pending_requests.push_back('{OP_ACCESS, 32'h8000_0000});
        pending_requests.push_back('{OP_ACCESS, 32'h1234_5678});
        set_capacity(5'd2);
        for (int i = 0; i < 6; i++) pending_requests.push_back('{OP_INSERT, 32'(i) + 32'h100});
        pending_requests.push_back('{OP_ACCESS, 32'h105});
        pending_requests.push_back('{OP_INSERT, 32'h200});
        set_capacity(5'd0);
        pending_requests.push_back('{OP_INSERT, 32'h300});
        pending_requests.push_back('{OP_INSERT, 32'h301});
        set_capacity(5'd31);

        // repeated accesses raise the count of one key
        rq = '{OP_ACCESS, 32'h301};
        repeat (200) pending_requests.push_back(rq);

        set_capacity(5'd16);
        queue_random(250, 40, 60);
        drain();
        send_idle_pct = 54;
        set_capacity(5'd4);
        queue_random(200, 10, 55);
        drain();
        recv_stall_pct = 54;
        send_idle_pct = 0;
        set_capacity(5'd1);
        queue_random(150, 4, 50);
        drain();
        send_idle_pct = 16;
        recv_stall_pct = 16;
        set_capacity(5'd9);
        queue_random(150, 20, 60);
        drain();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_capacity(5'd16);
        hold_cycles = 600;
        queue_random(150, 30, 65);
        drain();

        if (error_count == 0) begin
            $display("[lfu_cache_table] OK");
        end else begin
            $display("[lfu_cache_table] ERROR");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
hdl/lfu_pkg.sv
hdl/lfu_cell.sv
hdl/lfu_cache_table.sv
hdl/lfu_checker.sv
tb/sv/lfu_cache_table_tb.sv
